[src/dns_response_parser_defines.svh]
// Assertion macros shared by the DNS response parser RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DNS_RESPONSE_PARSER_DEFINES_SVH
`define DNS_RESPONSE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dns_rp_pkg.sv]
// Types, codes and constants of the DNS response parser.
// No dependencies; imported by the parser core, the result queue and the top level.
package dns_rp_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ADDR   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QUERY    = 3'd1,
    ST_RCODE    = 3'd2,
    ST_BADLABEL = 3'd3,
    ST_TOOLONG  = 3'd4,
    ST_LABELS   = 3'd5,
    ST_ALEN     = 3'd6,
    ST_TRUNC    = 3'd7
  } status_t;

  localparam int DEF_MAX_ANSWERS    = 10;
  localparam int DEF_MAX_ADDRESSES  = 16;
  localparam int DEF_NAME_BUF_BYTES = 256;
  localparam int DEF_MAX_LABELS     = 64;
  localparam int DEF_MAX_LABEL_LEN  = 63;

  localparam logic [7:0]  PTR_MARK = 8'hC0;
  localparam logic [7:0]  LEN_MASK = 8'h3F;
  localparam logic [15:0] TYPE_A   = 16'h0001;
  localparam logic [7:0]  DOT_CHAR = 8'h2E;

  // last byte offset of the header, question fixed part and answer fixed part
  localparam logic [3:0] HDR_LAST  = 4'd11;
  localparam logic [3:0] QFIX_LAST = 4'd3;
  localparam logic [3:0] AFIX_LAST = 4'd9;

  // name length plus one label plus separator never exceeds 256 + 64
  localparam int NL_SUM_W = 10;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [31:0] ipv4_address;
    status_t     status;
    logic [15:0] msg_id;
    logic        run_last;
  } result_t;

  // results produced by one accepted byte, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            room2;
  } q_stat_t;

endpackage

[src/dns_rp_fifo.sv]
// Result queue of the DNS response parser: takes up to two results a cycle and,
// while out_ready is high, gives one. Depends on dns_rp_pkg.
module dns_rp_fifo import dns_rp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item,
  output q_stat_t stat
);

  result_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];
  assign wr_ptr1   = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + Q_CW'(push.cnt) - Q_CW'(pop);
  end

  assign stat.count = cnt_r;
  assign stat.room2 = (cnt_r <= Q_CW'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/dns_rp_parser.sv]
// Parser core: phase machine and header/record fields, one message byte per beat.
// Depends on dns_rp_pkg; feeds its results to dns_rp_fifo.
module dns_rp_parser import dns_rp_pkg::*; #(
  parameter int MAX_ANSWERS    = DEF_MAX_ANSWERS,
  parameter int MAX_ADDRESSES  = DEF_MAX_ADDRESSES,
  parameter int NAME_BUF_BYTES = DEF_NAME_BUF_BYTES,
  parameter int MAX_LABELS     = DEF_MAX_LABELS,
  parameter int MAX_LABEL_LEN  = DEF_MAX_LABEL_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  localparam int LT_W = $clog2(MAX_LABELS);
  localparam int AK_W = $clog2(MAX_ADDRESSES + 1);
  localparam int NL_W = $clog2(NAME_BUF_BYTES + 1);

  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_QLEN  = 4'd1,
    PH_QCHR  = 4'd2,
    PH_QPTR  = 4'd3,
    PH_SLEN  = 4'd4,
    PH_SCHR  = 4'd5,
    PH_SPTR  = 4'd6,
    PH_QFIX  = 4'd7,
    PH_AFIX  = 4'd8,
    PH_RDATA = 4'd9,
    PH_DONE  = 4'd10
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      fc_r, fc_nxt;
  logic [15:0]     hid_r, hid_nxt;
  logic            qr_r, qr_nxt;
  logic [3:0]      rcode_r, rcode_nxt;
  logic [15:0]     qc_r, qc_nxt;
  logic [3:0]      al_r, al_nxt;
  logic [5:0]      ll_r, ll_nxt;
  logic [LT_W-1:0] lt_r, lt_nxt;
  logic [NL_W-1:0] nl_r, nl_nxt;
  logic [15:0]     rt_r, rt_nxt;
  logic [15:0]     rdl_r, rdl_nxt;
  logic [31:0]     as_r, as_nxt;
  logic [AK_W-1:0] ak_r, ak_nxt;
  logic            done_r, done_nxt;

  logic              emit_v, fin_v, fin7, fin_any, ans_go;
  kind_t             emit_kind;
  logic [7:0]        emit_char;
  logic [31:0]       emit_addr;
  status_t           fin_code;
  logic [3:0]        al_sel;
  logic [7:0]        top_bits;
  logic [LT_W:0]     lt_inc;
  logic [NL_SUM_W-1:0] nl_sum;
  logic [15:0]       rdl_full;
  logic [15:0]       tid_w;
  result_t           r_emit, r_fin;

  assign top_bits = data_byte & PTR_MARK;
  assign lt_inc   = {1'b0, lt_r} + 1'b1;
  assign nl_sum   = {{(NL_SUM_W - NL_W){1'b0}}, nl_r} + {2'b00, data_byte} + 1'b1;
  assign rdl_full = {rdl_r[15:8], data_byte};

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    hid_nxt   = hid_r;
    qr_nxt    = qr_r;
    rcode_nxt = rcode_r;
    qc_nxt    = qc_r;
    al_nxt    = al_r;
    ll_nxt    = ll_r;
    lt_nxt    = lt_r;
    nl_nxt    = nl_r;
    rt_nxt    = rt_r;
    rdl_nxt   = rdl_r;
    as_nxt    = as_r;
    ak_nxt    = ak_r;
    done_nxt  = done_r;
    emit_v    = 1'b0;
    emit_kind = KIND_CHAR;
    emit_char = 8'h00;
    emit_addr = 32'h0;
    fin_v     = 1'b0;
    fin_code  = ST_OK;
    ans_go    = 1'b0;
    al_sel    = al_r;

    unique case (phase_r)
      PH_HDR: begin
        case (fc_r)
          4'd0: hid_nxt = {data_byte, 8'h00};
          4'd1: hid_nxt[7:0] = data_byte;
          4'd2: qr_nxt = data_byte[7];
          4'd3: rcode_nxt = data_byte[3:0];
          4'd4: qc_nxt = {data_byte, 8'h00};
          4'd5: qc_nxt[7:0] = data_byte;
          4'd6: al_nxt = (data_byte != 8'h00) ? 4'(MAX_ANSWERS) : 4'd0;
          4'd7: begin
            if (al_r == 4'd0) begin
              al_nxt = (data_byte > 8'(MAX_ANSWERS)) ? 4'(MAX_ANSWERS) : data_byte[3:0];
            end
          end
          default: ;
        endcase
        fc_nxt = fc_r + 1'b1;
        if (fc_r == HDR_LAST) begin
          if (!qr_r) begin
            fin_v = 1'b1;
            fin_code = ST_QUERY;
          end else if (rcode_r != 4'd0) begin
            fin_v = 1'b1;
            fin_code = ST_RCODE;
          end else if (qc_r != 16'd0) begin
            lt_nxt = '0;
            nl_nxt = '0;
            phase_nxt = PH_QLEN;
          end else begin
            ans_go = 1'b1;
          end
        end
      end
      PH_QLEN: begin
        if (data_byte == 8'h00 || top_bits == PTR_MARK) begin
          if (lt_r == '0) begin
            fin_v = 1'b1;
            fin_code = ST_BADLABEL;
          end else begin
            emit_v = 1'b1;
            if (data_byte == 8'h00) begin
              fc_nxt = 4'd0;
              phase_nxt = (qc_r != 16'd0) ? PH_QFIX : PH_AFIX;
            end else begin
              phase_nxt = PH_QPTR;
            end
          end
        end else if (top_bits != 8'h00 || data_byte > 8'(MAX_LABEL_LEN)) begin
          fin_v = 1'b1;
          fin_code = ST_BADLABEL;
        end else if (nl_sum > NL_SUM_W'(NAME_BUF_BYTES)) begin
          fin_v = 1'b1;
          fin_code = ST_TOOLONG;
        end else if (lt_inc >= (LT_W + 1)'(MAX_LABELS)) begin
          fin_v = 1'b1;
          fin_code = ST_LABELS;
        end else begin
          if (lt_r != '0) begin
            emit_v = 1'b1;
            emit_char = DOT_CHAR;
          end
          lt_nxt = lt_inc[LT_W-1:0];
          nl_nxt = nl_sum[NL_W-1:0];
          ll_nxt = data_byte[5:0];
          phase_nxt = PH_QCHR;
        end
      end
      PH_QCHR: begin
        emit_v = 1'b1;
        emit_char = data_byte;
        ll_nxt = ll_r - 1'b1;
        if (ll_r == 6'd1) begin
          phase_nxt = PH_QLEN;
        end
      end
      PH_QPTR, PH_SPTR: begin
        fc_nxt = 4'd0;
        phase_nxt = (qc_r != 16'd0) ? PH_QFIX : PH_AFIX;
      end
      PH_SLEN: begin
        if (data_byte == 8'h00) begin
          fc_nxt = 4'd0;
          phase_nxt = (qc_r != 16'd0) ? PH_QFIX : PH_AFIX;
        end else if (top_bits == PTR_MARK) begin
          phase_nxt = PH_SPTR;
        end else if (top_bits != 8'h00) begin
          fin_v = 1'b1;
          fin_code = ST_BADLABEL;
        end else if (lt_inc >= (LT_W + 1)'(MAX_LABELS)) begin
          fin_v = 1'b1;
          fin_code = ST_LABELS;
        end else begin
          lt_nxt = lt_inc[LT_W-1:0];
          ll_nxt = 6'(data_byte & LEN_MASK);
          phase_nxt = PH_SCHR;
        end
      end
      PH_SCHR: begin
        ll_nxt = ll_r - 1'b1;
        if (ll_r == 6'd1) begin
          phase_nxt = PH_SLEN;
        end
      end
      PH_QFIX: begin
        fc_nxt = fc_r + 1'b1;
        if (fc_r == QFIX_LAST) begin
          qc_nxt = qc_r - 1'b1;
          if (qc_r != 16'd1) begin
            lt_nxt = '0;
            phase_nxt = PH_SLEN;
          end else begin
            ans_go = 1'b1;
          end
        end
      end
      PH_AFIX: begin
        case (fc_r)
          4'd0: rt_nxt = {data_byte, 8'h00};
          4'd1: rt_nxt[7:0] = data_byte;
          4'd8: rdl_nxt = {data_byte, 8'h00};
          4'd9: rdl_nxt = rdl_full;
          default: ;
        endcase
        fc_nxt = fc_r + 1'b1;
        if (fc_r == AFIX_LAST) begin
          if (rt_r == TYPE_A && rdl_full != 16'd4) begin
            fin_v = 1'b1;
            fin_code = ST_ALEN;
          end else if (rdl_full == 16'd0) begin
            al_nxt = al_r - 1'b1;
            al_sel = al_r - 1'b1;
            ans_go = 1'b1;
          end else begin
            as_nxt = 32'h0;
            phase_nxt = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        as_nxt = {as_r[23:0], data_byte};
        rdl_nxt = rdl_r - 1'b1;
        if (rdl_r == 16'd1) begin
          if (rt_r == TYPE_A && ak_r < AK_W'(MAX_ADDRESSES)) begin
            emit_v = 1'b1;
            emit_kind = KIND_ADDR;
            emit_addr = {as_r[23:0], data_byte};
            ak_nxt = ak_r + 1'b1;
          end
          al_nxt = al_r - 1'b1;
          al_sel = al_r - 1'b1;
          ans_go = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // start the next answer, or close the message when none is left
    if (ans_go) begin
      if (al_sel == 4'd0) begin
        fin_v = 1'b1;
        fin_code = ST_OK;
      end else begin
        lt_nxt = '0;
        phase_nxt = PH_SLEN;
      end
    end
    if (fin_v) begin
      phase_nxt = PH_DONE;
      done_nxt = 1'b1;
    end

    tid_w = hid_nxt;
    fin7  = last_byte && !done_r && !fin_v;

    if (last_byte) begin
      phase_nxt = PH_HDR;
      fc_nxt    = '0;
      hid_nxt   = '0;
      qr_nxt    = 1'b0;
      rcode_nxt = '0;
      qc_nxt    = '0;
      al_nxt    = '0;
      ll_nxt    = '0;
      lt_nxt    = '0;
      nl_nxt    = '0;
      rt_nxt    = '0;
      rdl_nxt   = '0;
      as_nxt    = '0;
      ak_nxt    = '0;
      done_nxt  = 1'b0;
    end
  end

  assign fin_any = fin_v || fin7;

  always_comb begin
    r_emit.kind           = emit_kind;
    r_emit.name_char      = emit_char;
    r_emit.ipv4_address   = emit_addr;
    r_emit.status         = ST_OK;
    r_emit.msg_id         = tid_w;
    r_emit.run_last       = !fin_any;

    r_fin.kind            = KIND_STATUS;
    r_fin.name_char       = 8'h00;
    r_fin.ipv4_address    = 32'h0;
    r_fin.status          = fin_v ? fin_code : ST_TRUNC;
    r_fin.msg_id          = tid_w;
    r_fin.run_last        = 1'b1;

    push.cnt = in_fire ? (2'(emit_v) + 2'(fin_any)) : 2'd0;
    push.r0  = emit_v ? r_emit : r_fin;
    push.r1  = r_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      fc_r    <= '0;
      hid_r   <= '0;
      qr_r    <= 1'b0;
      rcode_r <= '0;
      qc_r    <= '0;
      al_r    <= '0;
      ll_r    <= '0;
      lt_r    <= '0;
      nl_r    <= '0;
      rt_r    <= '0;
      rdl_r   <= '0;
      as_r    <= '0;
      ak_r    <= '0;
      done_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      hid_r   <= hid_nxt;
      qr_r    <= qr_nxt;
      rcode_r <= rcode_nxt;
      qc_r    <= qc_nxt;
      al_r    <= al_nxt;
      ll_r    <= ll_nxt;
      lt_r    <= lt_nxt;
      nl_r    <= nl_nxt;
      rt_r    <= rt_nxt;
      rdl_r   <= rdl_nxt;
      as_r    <= as_nxt;
      ak_r    <= ak_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

[src/dns_response_parser.sv]
// DNS response parser, top level: parser core plus result queue.
// Depends on dns_rp_pkg, dns_rp_parser, dns_rp_fifo and the assertion macro header.
//
// Usage:
//   in_*  : one message byte per beat, header first; in_last_byte marks the
//           final byte of a message. in_ready is high while the result queue
//           has room for two results.
//   out_* : result beats. item_kind tells a name character, an A-record
//           address or the end status; run_last marks the last result caused
//           by one input byte. Every message yields exactly one status.
//   Latency: the results of a byte are registered in the queue at the beat
//           edge; the first is offered on out_* in the next cycle if the queue was empty.
//   Throughput: one byte per cycle while in_ready is high. A byte yields 0, 1
//           or 2 results; the 4-entry queue drains one result a cycle while
//           out_ready is high and absorbs the surplus of bytes with two results.
//   Stall: while out_ready is low the queue fills and in_ready drops once
//           fewer than two entries are free; nothing is lost.
//   Reset: rst_n low (synchronous) empties the queue and puts the parser in
//           its header phase with all fields zero. A final byte does the same
//           to the parser after its results.
`include "dns_response_parser_defines.svh"
module dns_response_parser import dns_rp_pkg::*; #(
  parameter int MAX_ANSWERS    = DEF_MAX_ANSWERS,
  parameter int MAX_ADDRESSES  = DEF_MAX_ADDRESSES,
  parameter int NAME_BUF_BYTES = DEF_NAME_BUF_BYTES,
  parameter int MAX_LABELS     = DEF_MAX_LABELS,
  parameter int MAX_LABEL_LEN  = DEF_MAX_LABEL_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_name_char,
  output logic [31:0] out_ipv4_address,
  output logic [2:0]  out_status,
  output logic [15:0] out_msg_id,
  output logic        out_run_last
);

  push_t   push;
  q_stat_t q_stat;
  result_t out_item;
  logic    in_fire;
  logic    last_fire;

  assign in_ready  = q_stat.room2;
  assign in_fire   = in_valid && in_ready;
  assign last_fire = in_fire && in_last_byte;

  dns_rp_parser #(
    .MAX_ANSWERS   (MAX_ANSWERS),
    .MAX_ADDRESSES (MAX_ADDRESSES),
    .NAME_BUF_BYTES(NAME_BUF_BYTES),
    .MAX_LABELS    (MAX_LABELS),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .data_byte(in_data_byte),
    .last_byte(in_last_byte),
    .push     (push)
  );

  dns_rp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .stat     (q_stat)
  );

  assign out_item_kind      = out_item.kind;
  assign out_name_char      = out_item.name_char;
  assign out_ipv4_address   = out_item.ipv4_address;
  assign out_status         = out_item.status;
  assign out_msg_id         = out_item.msg_id;
  assign out_run_last       = out_item.run_last;

  // a final byte after the status gives nothing; otherwise its last result is a status
  `DRP_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= Q_CW'(Q_DEPTH), "result queue overflow")
  `DRP_ASSERT_NOW(a_last_stat, last_fire && push.cnt == 2'd1, push.r0.kind == KIND_STATUS, "no status")
  `DRP_ASSERT_NOW(a_pair_ends_status, push.cnt == 2'd2, push.r1.kind == KIND_STATUS, "pair lacks status")
  `DRP_ASSERT_NEXT(a_push_seen, in_fire && push.cnt != 2'd0, out_valid, "pushed result not offered")

endmodule
